FILE: src/tcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tick CPU scheduler package
// Shared types, state codes and constants for the tick-driven scheduler.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int SLOTS      = 8;
  localparam int MAX_BURSTS = 8;
  localparam int TICK_CAP   = 1000000;
  localparam int SW         = $clog2(SLOTS);
  localparam int BW         = $clog2(MAX_BURSTS);

  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_BLOCK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_STAT = 2'd2;

  localparam logic [1:0] ALG_FCFS = 2'd0;
  localparam logic [1:0] ALG_SJF  = 2'd1;
  localparam logic [1:0] ALG_PRIO = 2'd2;
  localparam logic [1:0] ALG_RR   = 2'd3;

  localparam logic [1:0] REG_ALG   = 2'd0;
  localparam logic [1:0] REG_PREEM = 2'd1;
  localparam logic [1:0] REG_QUANT = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADMIT,
    S_SELECT,
    S_SWITCH,
    S_COUNT,
    S_FINISH,
    S_UNBLOCK,
    S_REPORT
  } ctl_state_t;

  typedef struct packed {
    logic       load;
    logic       stat;
    logic       stopped;
    logic       scan_clear;
    logic       admit;
    logic       select;
    logic       switch_run;
    logic       count;
    logic       finish;
    logic       unblock;
    logic       report;
    logic [SW-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic stop;
  } ctl_status_t;

endpackage
`default_nettype wire

FILE: src/tick_cpu_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tick CPU scheduler
// Tick-driven FCFS, SJF, priority and round robin process scheduler.
// ----------------------------------------------------------------------------
// An item is accepted on a clock edge with start high and busy low.
// A load item writes one slot's record and burst entry and gives no
// result. A stat item, or a tick after the run has stopped, gives its
// result on done in the cycle after acceptance and keeps busy low.
// A running tick item walks the eight slots four times (admission,
// selection, time counting, unblocking) plus two single steps and a
// report step. Busy stays high throughout, and done rises at the same
// edge at which busy falls.
// Each result stands for one cycle with done high; the receiver cannot
// stall. Configuration writes (cfg_write, cfg_index, cfg_data) take effect at
// the edge. The user must make them only while the block is idle; the block
// does not check this. Synchronous reset clears all process state, counters
// and the tick, and sets first-run and completion times to minus one.
// ----------------------------------------------------------------------------
module tick_cpu_scheduler import tcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic [1:0]  operation,
  input  wire logic [2:0]  slot,
  input  wire logic [2:0]  burst_number,
  input  wire logic [15:0] process_id,
  input  wire logic [19:0] arrival_time,
  input  wire logic [7:0]  priority_level,
  input  wire logic [15:0] burst_duration,
  input  wire logic        burst_is_io,
  input  wire logic [3:0]  burst_total,
  output logic [19:0]      tick_base,
  output logic [15:0]      active_pid,
  output logic             cpu_idle,
  output logic             preempted,
  output logic             all_finished,
  output logic             limit_reached,
  output logic [19:0]      run_ticks,
  output logic [19:0]      wait_ticks,
  output logic [19:0]      io_ticks,
  output logic signed [20:0] completion_time,
  output logic signed [20:0] first_run_time,
  output logic [2:0]       slot_status
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  tcs_controller u_ctl (
    .clk, .rst, .start, .operation, .slot, .burst_number,
    .status, .cmd, .busy
  );

  tcs_datapath u_dp (
    .clk, .rst, .cmd, .status, .cfg_write, .cfg_index, .cfg_data,
    .in_slot(slot), .in_burst_number(burst_number), .in_process_id(process_id),
    .in_arrival_time(arrival_time), .in_priority_level(priority_level),
    .in_burst_duration(burst_duration), .in_burst_is_io(burst_is_io),
    .in_burst_total(burst_total), .done, .tick_base, .active_pid, .cpu_idle,
    .preempted, .all_finished, .limit_reached, .run_ticks, .wait_ticks,
    .io_ticks, .completion_time, .first_run_time, .slot_status
  );

endmodule
`default_nettype wire

FILE: src/tcs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tick CPU scheduler datapath
// Per-slot state, burst memory, selection scan and result registers.
// ----------------------------------------------------------------------------
module tcs_datapath import tcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_cmd_t    cmd,
  output ctl_status_t      status,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic [2:0]  in_slot,
  input  wire logic [2:0]  in_burst_number,
  input  wire logic [15:0] in_process_id,
  input  wire logic [19:0] in_arrival_time,
  input  wire logic [7:0]  in_priority_level,
  input  wire logic [15:0] in_burst_duration,
  input  wire logic        in_burst_is_io,
  input  wire logic [3:0]  in_burst_total,
  output logic             done,
  output logic [19:0]      tick_base,
  output logic [15:0]      active_pid,
  output logic             cpu_idle,
  output logic             preempted,
  output logic             all_finished,
  output logic             limit_reached,
  output logic [19:0]      run_ticks,
  output logic [19:0]      wait_ticks,
  output logic [19:0]      io_ticks,
  output logic signed [20:0] completion_time,
  output logic signed [20:0] first_run_time,
  output logic [2:0]       slot_status
);

  logic [1:0]  algorithm;
  logic        preemptive;
  logic [15:0] quantum;
  logic [19:0] time_limit;

  logic [2:0]  pstate   [SLOTS];
  logic        loaded   [SLOTS];
  logic [15:0] pid      [SLOTS];
  logic [19:0] arrival  [SLOTS];
  logic [7:0]  prio     [SLOTS];
  logic [3:0]  total    [SLOTS];
  logic [16:0] bursts   [SLOTS*MAX_BURSTS];
  logic [3:0]  bpos     [SLOTS];
  logic [16:0] remain   [SLOTS];
  logic [16:0] slice    [SLOTS];
  logic [23:0] qorder   [SLOTS];
  logic [19:0] c_run    [SLOTS];
  logic [19:0] c_rdy    [SLOTS];
  logic [19:0] c_blk    [SLOTS];
  logic signed [20:0] frun  [SLOTS];
  logic signed [20:0] compl [SLOTS];
  logic [19:0] tick;
  logic [23:0] order;
  logic        runner_ok;
  logic [SW-1:0] runner;
  logic        chosen_ok;
  logic [SW-1:0] chosen;
  logic        preempt_flag;
  logic        alive_any;
  logic [19:0] lim;
  logic [SW-1:0] nb_slot;
  logic [3:0]  nb_pos;
  logic [SW-1:0] rd_slot;
  logic        rd_first;
  logic [3:0]  rd_pos;
  logic [SW+BW-1:0] rd_addr;
  logic [16:0] burst_q;
  logic        c_better;

  always_comb begin
    alive_any = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (loaded[s] && pstate[s] != ST_DONE) alive_any = 1'b1;
    end
    if (time_limit == '0 || time_limit > 20'(TICK_CAP)) lim = 20'(TICK_CAP);
    else lim = time_limit;
    status.stop = !alive_any || tick >= lim;
    nb_slot = cmd.finish ? chosen : cmd.idx;
    nb_pos  = bpos[nb_slot] + 4'd1;
  end

  // The burst entry used in a cycle is fetched in the cycle before it.
  always_comb begin
    rd_slot = cmd.idx + SW'(1);
    if (cmd.scan_clear || cmd.finish) rd_slot = '0;
    else if (cmd.count) rd_slot = chosen;
    rd_first = cmd.scan_clear || cmd.admit;
    rd_pos = bpos[rd_slot] + 4'd1;
    rd_addr = {rd_slot, rd_first ? BW'(0) : rd_pos[BW-1:0]};
  end

  function automatic logic better_f(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic ra, rb;
    logic [16:0] ka, kb;
    ra = pstate[a] == ST_RUN;
    rb = pstate[b] == ST_RUN;
    ka = (algorithm == ALG_SJF) ? remain[a] : {9'd0, prio[a]};
    kb = (algorithm == ALG_SJF) ? remain[b] : {9'd0, prio[b]};
    if (algorithm == ALG_FCFS || algorithm == ALG_RR) begin
      if (ra != rb) return ra;
      if (qorder[a] != qorder[b]) return qorder[a] < qorder[b];
    end else begin
      if (!preemptive && ra != rb) return ra;
      if (ka != kb) return ka < kb;
      if (ra != rb) return ra;
    end
    return pid[a] < pid[b];
  endfunction

  assign c_better = better_f(cmd.idx, chosen);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bursts[{in_slot[SW-1:0], in_burst_number[BW-1:0]}] <= {in_burst_is_io, in_burst_duration};
    end
    burst_q <= bursts[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid[in_slot]     <= in_process_id;
      arrival[in_slot] <= in_arrival_time;
      prio[in_slot]    <= in_priority_level;
      if (in_burst_total == 4'd0) total[in_slot] <= 4'd1;
      else if (in_burst_total > 4'(MAX_BURSTS)) total[in_slot] <= 4'(MAX_BURSTS);
      else total[in_slot] <= in_burst_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ALG_FCFS; preemptive <= 1'b0; quantum <= 16'd4; time_limit <= '0;
      tick <= '0; order <= '0; runner_ok <= 1'b0; runner <= '0;
      chosen_ok <= 1'b0; chosen <= '0; preempt_flag <= 1'b0; done <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        pstate[s] <= ST_NEW; loaded[s] <= 1'b0; bpos[s] <= '0; remain[s] <= '0;
        slice[s] <= '0; qorder[s] <= '0; c_run[s] <= '0; c_rdy[s] <= '0; c_blk[s] <= '0;
        frun[s] <= -21'sd1; compl[s] <= -21'sd1;
      end
    end else begin
      done <= cmd.stat || cmd.stopped || cmd.report;
      if (cfg_write) begin
        case (cfg_index)
          REG_ALG:   algorithm  <= cfg_data[1:0];
          REG_PREEM: preemptive <= cfg_data[0];
          REG_QUANT: quantum    <= cfg_data[15:0];
          REG_LIMIT: time_limit <= cfg_data;
          default:   ;
        endcase
      end
      if (cmd.load) begin
        loaded[in_slot] <= 1'b1;
      end
      if (cmd.stat || cmd.stopped) begin
        tick_base <= tick; active_pid <= '0; cpu_idle <= cmd.stopped; preempted <= 1'b0;
        all_finished <= !alive_any;
        limit_reached <= time_limit != '0 && tick >= lim && alive_any;
        run_ticks  <= cmd.stat ? c_run[in_slot] : '0;
        wait_ticks <= cmd.stat ? c_rdy[in_slot] : '0;
        io_ticks   <= cmd.stat ? c_blk[in_slot] : '0;
        completion_time <= !cmd.stat ? '0
                           : (pstate[in_slot] == ST_DONE) ? compl[in_slot] : -21'sd1;
        first_run_time <= cmd.stat ? frun[in_slot] : '0;
        slot_status <= cmd.stat ? pstate[in_slot] : ST_NEW;
      end
      if (cmd.scan_clear) begin
        chosen_ok <= 1'b0; preempt_flag <= 1'b0;
      end
      if (cmd.admit) begin
        if (loaded[cmd.idx] && pstate[cmd.idx] == ST_NEW && arrival[cmd.idx] <= tick) begin
          pstate[cmd.idx] <= ST_READY; qorder[cmd.idx] <= order; order <= order + 24'd1;
          remain[cmd.idx] <= (burst_q[15:0] == '0) ? 17'd1 : {1'b0, burst_q[15:0]};
        end
      end
      if (cmd.select) begin
        if (loaded[cmd.idx] && (pstate[cmd.idx] == ST_READY || pstate[cmd.idx] == ST_RUN)
            && (!chosen_ok || c_better)) begin
          chosen_ok <= 1'b1; chosen <= cmd.idx;
        end
      end
      if (cmd.switch_run) begin
        if (chosen_ok != runner_ok || (chosen_ok && chosen != runner)) begin
          if (runner_ok && pstate[runner] == ST_RUN) begin
            pstate[runner] <= ST_READY; qorder[runner] <= order; order <= order + 24'd1;
            slice[runner] <= '0; preempt_flag <= 1'b1;
          end
          if (chosen_ok) begin
            pstate[chosen] <= ST_RUN;
            if (frun[chosen] < 0) frun[chosen] <= signed'({1'b0, tick});
            if (algorithm == ALG_RR) slice[chosen] <= {1'b0, quantum};
          end
          runner_ok <= chosen_ok; runner <= chosen;
        end
      end
      if (cmd.count) begin
        if (loaded[cmd.idx]) begin
          case (pstate[cmd.idx])
            ST_RUN: begin
              c_run[cmd.idx] <= c_run[cmd.idx] + 20'd1;
              if (remain[cmd.idx] != '0) remain[cmd.idx] <= remain[cmd.idx] - 17'd1;
              if (algorithm == ALG_RR && slice[cmd.idx] != '0)
                slice[cmd.idx] <= slice[cmd.idx] - 17'd1;
            end
            ST_READY: c_rdy[cmd.idx] <= c_rdy[cmd.idx] + 20'd1;
            ST_BLOCK: begin
              c_blk[cmd.idx] <= c_blk[cmd.idx] + 20'd1;
              if (remain[cmd.idx] != '0) remain[cmd.idx] <= remain[cmd.idx] - 17'd1;
            end
            default: ;
          endcase
        end
        if (cmd.idx == SW'(SLOTS-1)) tick <= tick + 20'd1;
      end
      if (cmd.finish && chosen_ok) begin
        if (remain[chosen] == '0) begin
          bpos[chosen] <= nb_pos;
          if (nb_pos >= total[chosen]) begin
            pstate[chosen] <= ST_DONE; compl[chosen] <= signed'({1'b0, tick});
            runner_ok <= 1'b0;
          end else begin
            remain[chosen] <= (burst_q[15:0] == '0) ? 17'd1 : {1'b0, burst_q[15:0]};
            if (burst_q[16]) begin
              pstate[chosen] <= ST_BLOCK; runner_ok <= 1'b0;
            end
          end
        end else if (algorithm == ALG_RR && slice[chosen] == '0 && pstate[chosen] == ST_RUN) begin
          pstate[chosen] <= ST_READY; qorder[chosen] <= order; order <= order + 24'd1;
          runner_ok <= 1'b0;
        end
      end
      if (cmd.unblock) begin
        if (loaded[cmd.idx] && pstate[cmd.idx] == ST_BLOCK && remain[cmd.idx] == '0) begin
          bpos[cmd.idx] <= nb_pos;
          if (nb_pos >= total[cmd.idx]) begin
            pstate[cmd.idx] <= ST_DONE; compl[cmd.idx] <= signed'({1'b0, tick});
          end else begin
            remain[cmd.idx] <= (burst_q[15:0] == '0) ? 17'd1 : {1'b0, burst_q[15:0]};
            if (!burst_q[16]) begin
              pstate[cmd.idx] <= ST_READY; qorder[cmd.idx] <= order; order <= order + 24'd1;
            end
          end
        end
      end
      if (cmd.report) begin
        tick_base <= tick - 20'd1;
        active_pid <= chosen_ok ? pid[chosen] : '0;
        cpu_idle <= !chosen_ok; preempted <= preempt_flag;
        all_finished <= !alive_any;
        limit_reached <= time_limit != '0 && tick >= lim && alive_any;
        run_ticks <= '0; wait_ticks <= '0; io_ticks <= '0;
        completion_time <= '0; first_run_time <= '0; slot_status <= ST_NEW;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/tcs_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tick CPU scheduler controller
// Sequences the per-slot passes of one tick and drives the datapath.
// ----------------------------------------------------------------------------
module tcs_controller import tcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  operation,
  input  wire logic [2:0]  slot,
  input  wire logic [2:0]  burst_number,
  input  wire ctl_status_t status,
  output ctl_cmd_t         cmd,
  output logic             busy
);

  ctl_state_t state, state_next;
  logic [SW-1:0] idx, idx_next;
  logic last;

  assign last = idx == SW'(SLOTS-1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0;
    end else begin
      state <= state_next; idx <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx;
    busy = state != S_IDLE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_LOAD: cmd.load = 32'(slot) < SLOTS && 32'(burst_number) < MAX_BURSTS;
            OP_STAT: cmd.stat = 1'b1;
            OP_TICK: begin
              if (status.stop) cmd.stopped = 1'b1;
              else begin
                cmd.scan_clear = 1'b1; state_next = S_ADMIT; idx_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADMIT: begin
        cmd.admit = 1'b1; idx_next = idx + 1'b1;
        if (last) begin state_next = S_SELECT; idx_next = '0; end
      end
      S_SELECT: begin
        cmd.select = 1'b1; idx_next = idx + 1'b1;
        if (last) begin state_next = S_SWITCH; idx_next = '0; end
      end
      S_SWITCH: begin
        cmd.switch_run = 1'b1; state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1; idx_next = idx + 1'b1;
        if (last) begin state_next = S_FINISH; idx_next = '0; end
      end
      S_FINISH: begin
        cmd.finish = 1'b1; state_next = S_UNBLOCK;
      end
      S_UNBLOCK: begin
        cmd.unblock = 1'b1; idx_next = idx + 1'b1;
        if (last) begin state_next = S_REPORT; idx_next = '0; end
      end
      S_REPORT: begin
        cmd.report = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
